>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define TPSB_ASSERT_IMP(name, clk, rst_n, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define TPSB_ASSERT_NXT(name, clk, rst_n, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hw/rtl/tpsb_pkg.sv
// Types and constants of the tiered poll scheduler with timeout breaker.
`timescale 1ns / 1ps
`default_nettype none

package tpsb_pkg;

    // Event codes carried by the op field
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_RESULT    = 3'd1,
        OP_FG_REPORT = 3'd2,
        OP_SUSPEND   = 3'd3,
        OP_KICK      = 3'd4
    } t_op;

    // Breaker health levels
    typedef enum logic [1:0] {
        HEALTH_OK       = 2'd0,
        HEALTH_DEGRADED = 2'd1,
        HEALTH_DEAD     = 2'd2
    } t_health;

    // Configuration register indexes
    localparam logic [2:0] CFG_IDLE_IV   = 3'd0;
    localparam logic [2:0] CFG_ACTIVE_IV = 3'd1;
    localparam logic [2:0] CFG_SIGNAL_IV = 3'd2;
    localparam logic [2:0] CFG_CELL_IV   = 3'd3;
    localparam logic [2:0] CFG_SCALE     = 3'd4;
    localparam logic [2:0] CFG_ENABLE    = 3'd5;

    // Configuration reset values
    localparam logic [15:0] RST_IDLE_IV   = 16'd15000;
    localparam logic [15:0] RST_ACTIVE_IV = 16'd5000;
    localparam logic [15:0] RST_SIGNAL_IV = 16'd10000;
    localparam logic [15:0] RST_CELL_IV   = 16'd10000;
    localparam logic [4:0]  RST_SCALE     = 5'd1;

    // Speed factors
    localparam logic [2:0] SPEED_ONE  = 3'd1;
    localparam logic [2:0] SPEED_TWO  = 3'd2;
    localparam logic [2:0] SPEED_FOUR = 3'd4;

    // Timing and breaker constants
    localparam int unsigned HOLD_MS        = 30000;
    localparam int unsigned DEFAULT_GAP_MS = 1000;
    localparam int unsigned SEC_MS         = 1000;
    localparam int unsigned SOFT_HOLD_MS   = 60000;
    localparam int unsigned BUSY_DEPTH     = 3;
    localparam logic [7:0]  SOFT_LIMIT     = 8'd3;
    localparam logic [7:0]  HARD_LIMIT     = 8'd10;
    localparam logic [7:0]  RUN_MAX        = 8'd255;
    localparam int unsigned JIT_BASE       = 8000;
    localparam int unsigned DIV_CONST      = 10000;

    // Datapath widths of the shared multiplier and the divider
    localparam int unsigned MUL_A_W   = 21;
    localparam int unsigned MUL_B_W   = 17;
    localparam int unsigned PROD_W    = 38;
    localparam int unsigned DIV_RADIX = 5;
    localparam int unsigned DIV_STEPS = 5;
    localparam int unsigned QUO_W     = DIV_RADIX * DIV_STEPS;
    localparam int unsigned REM_W     = 14;
    localparam int unsigned TRIAL_W   = REM_W + 1;
    localparam int unsigned IV_W      = QUO_W + 2;
    localparam int unsigned SUSP_W    = 26;
    localparam int unsigned CNT_W     = 3;

endpackage

`default_nettype wire

>>> hw/rtl/tiered_poll_scheduler_breaker.sv
// Top level of the tiered poll scheduler with timeout circuit breaker.
//
// Input channel: i_valid with o_stall; an event is taken when i_valid is high
// and o_stall is low. o_stall is high while an event is being worked on.
// Output channel: o_valid with i_stall; one result per event, held in an
// output register until the receiver drops i_stall. The next event may be
// taken while a result still waits there.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data; write only when idle.
// Non-tick events pass through S_PREP, S_EXEC and S_DONE. A tick passes S_FG
// and, when polling runs, per tier S_CHECK, followed by S_UPDATE when due with
// a zero base, or by S_MUL1, S_MUL2, S_DIV and S_UPDATE when due with an
// interval to compute, and ends in S_DONE. The input is free again in the same
// cycle as the result is loaded into the output register.
// The interval of each due tier goes through one shared 21x17 multiplier
// twice, then a divide by 10000 that resolves 5 quotient bits a cycle.
// Results wait in the output register while i_stall is high; a finished event
// then holds in its last state until the register frees up.
// Reset (synchronous, active low) restores the configuration defaults, clears
// all tier due times and the breaker, and leaves the block idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tiered_poll_scheduler_breaker #(
    parameter int unsigned TIME_BITS = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // event channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [47:0] i_now_ms,
    input  wire logic        i_result_ok,
    input  wire logic        i_result_timeout,
    input  wire logic [7:0]  i_queue_depth,
    input  wire logic [15:0] i_suspend_seconds,
    input  wire logic [13:0] i_jitter_zero,
    input  wire logic [13:0] i_jitter_one,
    input  wire logic [13:0] i_jitter_two,
    input  wire logic        i_link_found,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_fire_mask,
    output logic [2:0]       o_skip_mask,
    output logic [1:0]       o_health,
    output logic [2:0]       o_slow_factor,
    output logic             o_in_foreground,
    output logic             o_is_suspended
);

    import tpsb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_EXEC,
        S_FG,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef logic [TIME_BITS-1:0] t_time;

    // Configuration registers
    logic [15:0] r_cfg_idle_iv;
    logic [15:0] r_cfg_active_iv;
    logic [15:0] r_cfg_signal_iv;
    logic [15:0] r_cfg_cell_iv;
    logic [4:0]  r_cfg_scale;
    logic        r_cfg_enable;

    // Scheduler and breaker state
    t_state      r_state;
    t_time       r_due [0:2];
    logic [7:0]  r_run;
    t_health     r_health;
    logic [2:0]  r_speed;
    t_time       r_susp_end;
    t_time       r_last_act;
    logic        r_fg;

    // Latched event payload
    logic [2:0]  r_op;
    t_time       r_now;
    logic        r_ok;
    logic        r_tmo;
    logic [7:0]  r_qdepth;
    logic [15:0] r_secs;
    logic [13:0] r_jit0;
    logic [13:0] r_jit1;
    logic [13:0] r_jit2;
    logic        r_link;

    // Sequencer working registers
    logic [1:0]        r_tier;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [2:0]        r_fire;
    logic [2:0]        r_skip;

    // Output register
    logic        r_o_valid;
    logic [2:0]  r_o_fire;
    logic [2:0]  r_o_skip;
    logic [1:0]  r_o_health;
    logic [2:0]  r_o_speed;
    logic        r_o_fg;
    logic        r_o_susp;

    // Combinational helpers
    logic               accept;
    logic [15:0]        act_iv;
    logic [15:0]        idle_iv;
    logic [15:0]        base_iv;
    logic [13:0]        jit;
    logic [MUL_B_W-1:0] jit_mult;
    logic [4:0]         sc_eff;
    logic               tier_on;
    logic               tier_due;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [REM_W-1:0]   n_div_rem;
    logic [QUO_W-1:0]   n_div_quo;
    logic [IV_W-1:0]    iv;
    logic [IV_W-1:0]    gap;
    logic               busy;
    t_time              n_due;
    t_time              fg_diff;
    logic               n_fg;
    logic               blocked;
    logic [SUSP_W-1:0]  susp_amt;
    t_time              n_susp_end;
    logic [7:0]         run_inc;

    // Terms for the checks at the end
    logic               pair_ok;
    logic               res_skip;
    logic               no_fire;
    logic               res_poll;
    logic               res_awake;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_idle_iv   <= RST_IDLE_IV;
            r_cfg_active_iv <= RST_ACTIVE_IV;
            r_cfg_signal_iv <= RST_SIGNAL_IV;
            r_cfg_cell_iv   <= RST_CELL_IV;
            r_cfg_scale     <= RST_SCALE;
            r_cfg_enable    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDLE_IV:   r_cfg_idle_iv   <= i_cfg_data;
                CFG_ACTIVE_IV: r_cfg_active_iv <= i_cfg_data;
                CFG_SIGNAL_IV: r_cfg_signal_iv <= i_cfg_data;
                CFG_CELL_IV:   r_cfg_cell_iv   <= i_cfg_data;
                CFG_SCALE:     r_cfg_scale     <= i_cfg_data[4:0];
                CFG_ENABLE:    r_cfg_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Select the intervals and jitter of the current tier
    always_comb begin
        case (r_tier)
            2'd0: begin
                act_iv  = r_cfg_active_iv;
                idle_iv = r_cfg_idle_iv;
                jit     = r_jit0;
            end
            2'd1: begin
                act_iv  = r_cfg_signal_iv;
                idle_iv = '0;
                jit     = r_jit1;
            end
            default: begin
                act_iv  = r_cfg_cell_iv;
                idle_iv = '0;
                jit     = r_jit2;
            end
        endcase
    end

    assign base_iv  = (r_fg && act_iv != '0) ? act_iv : idle_iv;
    assign tier_on  = (idle_iv != '0 || act_iv != '0) && (r_tier == 2'd0 || r_fg);
    assign tier_due = (r_now >= r_due[r_tier]);
    assign jit_mult = MUL_B_W'(JIT_BASE) + MUL_B_W'({jit, 2'b00});
    assign sc_eff   = (r_cfg_scale == '0) ? 5'd1 : r_cfg_scale;
    assign busy     = (r_qdepth >= 8'(BUSY_DEPTH));

    // Shared multiplier: base times scale, then times jitter factor, or seconds
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = MUL_A_W'(base_iv);
                mul_b = MUL_B_W'(sc_eff);
            end
            S_MUL2: begin
                mul_a = r_acc[MUL_A_W-1:0];
                mul_b = jit_mult;
            end
            default: begin
                mul_a = MUL_A_W'(r_secs);
                mul_b = MUL_B_W'(SEC_MS);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Divide by 10000: resolve DIV_RADIX quotient bits a cycle
    always_comb begin : div_step
        logic [TRIAL_W-1:0] trial;
        n_div_rem = r_rem;
        n_div_quo = r_acc[QUO_W-1:0];
        trial     = '0;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial     = {n_div_rem, n_div_quo[QUO_W-1]};
            n_div_quo = {n_div_quo[QUO_W-2:0], 1'b0};
            if (trial >= TRIAL_W'(DIV_CONST)) begin
                n_div_rem    = REM_W'(trial - TRIAL_W'(DIV_CONST));
                n_div_quo[0] = 1'b1;
            end else begin
                n_div_rem = trial[REM_W-1:0];
            end
        end
    end

    // Apply the speed factor and pick the re-arm gap
    always_comb begin
        case (r_speed)
            SPEED_TWO:  iv = {1'b0, r_acc[QUO_W-1:0], 1'b0};
            SPEED_FOUR: iv = {r_acc[QUO_W-1:0], 2'b00};
            default:    iv = {2'b00, r_acc[QUO_W-1:0]};
        endcase
        if (iv == '0) begin
            gap = IV_W'(DEFAULT_GAP_MS);
        end else if (busy) begin
            gap = iv >> 1;
        end else begin
            gap = iv;
        end
    end

    assign n_due = r_now + TIME_BITS'(gap);

    // Foreground hold and polling gate
    assign fg_diff = r_now - r_last_act;
    assign n_fg    = (r_last_act != '0) && (fg_diff < TIME_BITS'(HOLD_MS));
    assign blocked = (r_now < r_susp_end) || (r_health == HEALTH_DEAD) || !r_link
                     || !r_cfg_enable;

    // Suspend end time and timeout count
    assign susp_amt   = (r_op == OP_SUSPEND) ? r_acc[SUSP_W-1:0] : SUSP_W'(SOFT_HOLD_MS);
    assign n_susp_end = r_now + TIME_BITS'(susp_amt);
    assign run_inc    = (r_run == RUN_MAX) ? r_run : r_run + 8'd1;

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            for (int t = 0; t < 3; t++) begin
                r_due[t] <= '0;
            end
            r_run      <= '0;
            r_health   <= HEALTH_OK;
            r_speed    <= SPEED_ONE;
            r_susp_end <= '0;
            r_last_act <= '0;
            r_fg       <= 1'b0;
            r_tier     <= '0;
            r_cnt      <= '0;
            r_fire     <= '0;
            r_skip     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // drop the result once taken, unless a finished event reloads it
            if (r_o_valid && !i_stall && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_op;
                        r_now    <= TIME_BITS'(i_now_ms);
                        r_ok     <= i_result_ok;
                        r_tmo    <= i_result_timeout;
                        r_qdepth <= i_queue_depth;
                        r_secs   <= i_suspend_seconds;
                        r_jit0   <= i_jitter_zero;
                        r_jit1   <= i_jitter_one;
                        r_jit2   <= i_jitter_two;
                        r_link   <= i_link_found;
                        r_fire   <= '0;
                        r_skip   <= '0;
                        r_state  <= (i_op == OP_TICK) ? S_FG : S_PREP;
                    end
                end

                S_PREP: begin
                    // seconds to milliseconds for a suspend
                    r_acc   <= mul_p;
                    r_state <= S_EXEC;
                end

                S_EXEC: begin
                    case (r_op)
                        OP_RESULT: begin
                            if (r_ok) begin
                                r_run    <= '0;
                                r_health <= HEALTH_OK;
                                if (r_speed != SPEED_ONE) begin
                                    r_speed <= SPEED_ONE;
                                    for (int t = 0; t < 3; t++) begin
                                        if (r_due[t] > r_now) begin
                                            r_due[t] <= r_now;
                                        end
                                    end
                                end
                            end else if (r_tmo) begin
                                r_run <= run_inc;
                                if (run_inc == SOFT_LIMIT && r_health == HEALTH_OK) begin
                                    r_health   <= HEALTH_DEGRADED;
                                    r_speed    <= SPEED_TWO;
                                    r_susp_end <= n_susp_end;
                                    for (int t = 0; t < 3; t++) begin
                                        r_due[t] <= n_susp_end;
                                    end
                                end else if (run_inc >= HARD_LIMIT
                                             && r_health != HEALTH_DEAD) begin
                                    r_health <= HEALTH_DEAD;
                                    r_speed  <= SPEED_FOUR;
                                end
                            end
                        end
                        OP_FG_REPORT: begin
                            r_last_act <= r_now;
                        end
                        OP_SUSPEND: begin
                            r_susp_end <= n_susp_end;
                            for (int t = 0; t < 3; t++) begin
                                r_due[t] <= n_susp_end;
                            end
                        end
                        OP_KICK: begin
                            for (int t = 0; t < 3; t++) begin
                                if (r_due[t] > r_now) begin
                                    r_due[t] <= r_now;
                                end
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_DONE;
                end

                S_FG: begin
                    r_fg   <= n_fg;
                    r_tier <= '0;
                    // the gate does not depend on the foreground flag
                    r_state <= blocked ? S_DONE : S_CHECK;
                end

                S_CHECK: begin
                    if (tier_on && tier_due) begin
                        if (base_iv == '0) begin
                            r_acc   <= '0;
                            r_state <= S_UPDATE;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end else if (r_tier == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_tier <= r_tier + 2'd1;
                    end
                end

                S_MUL1: begin
                    r_acc   <= mul_p;
                    r_state <= S_MUL2;
                end

                S_MUL2: begin
                    r_acc   <= mul_p;
                    r_rem   <= REM_W'(mul_p[PROD_W-1:QUO_W]);
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_acc[QUO_W-1:0] <= n_div_quo;
                    r_rem            <= n_div_rem;
                    r_cnt            <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_UPDATE;
                    end
                end

                S_UPDATE: begin
                    // re-arm the tier and record fire or skip
                    r_due[r_tier] <= n_due;
                    if (busy) begin
                        r_skip[r_tier] <= 1'b1;
                    end else begin
                        r_fire[r_tier] <= 1'b1;
                    end
                    if (r_tier == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_tier  <= r_tier + 2'd1;
                        r_state <= S_CHECK;
                    end
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_fire   <= r_fire;
                        r_o_skip   <= r_skip;
                        r_o_health <= r_health;
                        r_o_speed  <= r_speed;
                        r_o_fg     <= r_fg;
                        r_o_susp   <= (r_now < r_susp_end);
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_fire_mask     = r_o_fire;
    assign o_skip_mask     = r_o_skip;
    assign o_health        = r_o_health;
    assign o_slow_factor   = r_o_speed;
    assign o_in_foreground = r_o_fg;
    assign o_is_suspended  = r_o_susp;

    // Gather the checked conditions
    assign pair_ok   = (r_health == HEALTH_OK && r_speed == SPEED_ONE)
                       || (r_health == HEALTH_DEGRADED && r_speed == SPEED_TWO)
                       || (r_health == HEALTH_DEAD && r_speed == SPEED_FOUR);
    assign res_skip  = o_valid && (o_skip_mask != 3'b000);
    assign no_fire   = (o_fire_mask == 3'b000);
    assign res_poll  = o_valid && (o_fire_mask != 3'b000 || o_skip_mask != 3'b000);
    assign res_awake = !o_is_suspended && (o_health != HEALTH_DEAD);

    // Breaker level and speed factor move together
    `TPSB_ASSERT_IMP(a_health_speed, i_clk, i_rst_n, 1'b1, pair_ok, "level and speed disagree")

    // One queue depth per tick: a skip excludes any fire
    `TPSB_ASSERT_IMP(a_skip_excl_fire, i_clk, i_rst_n, res_skip, no_fire, "fired and skipped")

    // Tiers only run while awake and alive
    `TPSB_ASSERT_IMP(a_poll_awake, i_clk, i_rst_n, res_poll, res_awake, "polled while held")

    // An accepted event holds off the next one
    `TPSB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, o_stall, "no busy after accept")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the tiered poll scheduler with timeout breaker.
`timescale 1ns / 1ps

module tb;
    import tpsb_pkg::*;

    // Op codes the block must ignore
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned RUN_SWEEP     = int'(RUN_MAX) + 3;

    typedef struct {
        logic [2:0]  op;
        logic [47:0] now_ms;
        logic        result_ok;
        logic        result_timeout;
        logic [7:0]  queue_depth;
        logic [15:0] suspend_seconds;
        logic [13:0] jitter [3];
        logic        link_found;
    } poll_event_t;

    typedef struct packed {
        logic [2:0] fire;
        logic [2:0] skip;
        logic [1:0] health;
        logic [2:0] slow;
        logic       fg;
        logic       susp;
    } status_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_op;
    logic [47:0] i_now_ms;
    logic        i_result_ok;
    logic        i_result_timeout;
    logic [7:0]  i_queue_depth;
    logic [15:0] i_suspend_seconds;
    logic [13:0] i_jitter_zero;
    logic [13:0] i_jitter_one;
    logic [13:0] i_jitter_two;
    logic        i_link_found;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_fire_mask;
    logic [2:0]  o_skip_mask;
    logic [1:0]  o_health;
    logic [2:0]  o_slow_factor;
    logic        o_in_foreground;
    logic        o_is_suspended;

    // Pacing controls
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycle_count = 0;

    // Expected statuses, oldest first
    status_t pending_status [$];

    // Scheduler state as predicted
    logic [47:0] due_ms [3];
    logic [7:0]  tmo_run;
    t_health     hlth;
    logic [2:0]  speed;
    logic [47:0] susp_end;
    logic [47:0] last_fg;
    logic        fg_flag;
    logic [15:0] cfg_idle_iv, cfg_active_iv, cfg_signal_iv, cfg_cell_iv;
    logic [4:0]  cfg_scale;
    logic        cfg_poll_en;

    logic [47:0] clock_ms = '0;
    int unsigned errors = 0;
    int unsigned n_events = 0, n_ticks = 0, n_fired = 0, n_skipped = 0;
    int unsigned n_degraded = 0, n_dead = 0;

    tiered_poll_scheduler_breaker u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_now_ms         (i_now_ms),
        .i_result_ok      (i_result_ok),
        .i_result_timeout (i_result_timeout),
        .i_queue_depth    (i_queue_depth),
        .i_suspend_seconds(i_suspend_seconds),
        .i_jitter_zero    (i_jitter_zero),
        .i_jitter_one     (i_jitter_one),
        .i_jitter_two     (i_jitter_two),
        .i_link_found     (i_link_found),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_fire_mask      (o_fire_mask),
        .o_skip_mask      (o_skip_mask),
        .o_health         (o_health),
        .o_slow_factor    (o_slow_factor),
        .o_in_foreground  (o_in_foreground),
        .o_is_suspended   (o_is_suspended)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out, %0d results outstanding", $time, pending_status.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: hold off for a requested stretch, else stall at random
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void restore_defaults();
        for (int t = 0; t < 3; t++) due_ms[t] = '0;
        tmo_run       = '0;
        hlth          = HEALTH_OK;
        speed         = SPEED_ONE;
        susp_end      = '0;
        last_fg       = '0;
        fg_flag       = 1'b0;
        cfg_idle_iv   = RST_IDLE_IV;
        cfg_active_iv = RST_ACTIVE_IV;
        cfg_signal_iv = RST_SIGNAL_IV;
        cfg_cell_iv   = RST_CELL_IV;
        cfg_scale     = RST_SCALE;
        cfg_poll_en   = 1'b1;
    endfunction

    function automatic logic [15:0] tier_idle_iv(input int t);
        return (t == 0) ? cfg_idle_iv : 16'd0;
    endfunction

    function automatic logic [15:0] tier_active_iv(input int t);
        case (t)
            0:       return cfg_active_iv;
            1:       return cfg_signal_iv;
            default: return cfg_cell_iv;
        endcase
    endfunction

    // Re-arm period of one tier: scaled, jittered, slowed by the breaker
    function automatic logic [63:0] tier_period(input int t, input logic [13:0] jit);
        logic [63:0] base, sc, prod;
        base = (fg_flag && tier_active_iv(t) != 0) ? 64'(tier_active_iv(t))
                                                   : 64'(tier_idle_iv(t));
        if (base == 0) return '0;
        sc = (cfg_scale == 0) ? 64'd1 : 64'(cfg_scale);
        prod = base * sc;
        prod = prod * (JIT_BASE + 4 * jit) / DIV_CONST;
        return prod * speed;
    endfunction

    function automatic void kick_tiers(input logic [47:0] now);
        for (int t = 0; t < 3; t++)
            if (due_ms[t] > now) due_ms[t] = now;
    endfunction

    function automatic void suspend_tiers(input logic [47:0] now, input logic [63:0] span);
        susp_end = now + span;
        for (int t = 0; t < 3; t++) due_ms[t] = susp_end;
    endfunction

    function automatic void poll_tiers(input poll_event_t ev, inout status_t st);
        logic [47:0] now, gap;
        logic [63:0] iv;
        now = ev.now_ms;
        gap = now - last_fg;
        fg_flag = (last_fg != 0) && (gap < HOLD_MS);
        if (now < susp_end || hlth == HEALTH_DEAD || !ev.link_found || !cfg_poll_en)
            return;
        for (int t = 0; t < 3; t++) begin
            if (tier_idle_iv(t) == 0 && tier_active_iv(t) == 0) continue;
            if (t != 0 && !fg_flag) continue;
            if (now < due_ms[t]) continue;
            iv = tier_period(t, ev.jitter[t]);
            if (ev.queue_depth >= BUSY_DEPTH) begin
                st.skip[t] = 1'b1;
                n_skipped++;
                due_ms[t] = now + ((iv != 0) ? iv / 2 : 64'(DEFAULT_GAP_MS));
            end else begin
                st.fire[t] = 1'b1;
                n_fired++;
                due_ms[t] = now + ((iv != 0) ? iv : 64'(DEFAULT_GAP_MS));
            end
        end
    endfunction

    function automatic void apply_result(input poll_event_t ev);
        if (ev.result_ok) begin
            tmo_run = '0;
            hlth = HEALTH_OK;
            if (speed != SPEED_ONE) begin
                speed = SPEED_ONE;
                kick_tiers(ev.now_ms);
            end
        end else if (ev.result_timeout) begin
            if (tmo_run != RUN_MAX) tmo_run++;
            if (tmo_run == SOFT_LIMIT && hlth == HEALTH_OK) begin
                hlth = HEALTH_DEGRADED;
                speed = SPEED_TWO;
                suspend_tiers(ev.now_ms, 64'(SOFT_HOLD_MS));
                n_degraded++;
            end else if (tmo_run >= HARD_LIMIT && hlth != HEALTH_DEAD) begin
                hlth = HEALTH_DEAD;
                speed = SPEED_FOUR;
                n_dead++;
            end
        end
    endfunction

    // Advance the predicted scheduler by one event and return its status
    function automatic status_t advance_scheduler(input poll_event_t ev);
        status_t st;
        st = '0;
        case (ev.op)
            OP_TICK: begin
                n_ticks++;
                poll_tiers(ev, st);
            end
            OP_RESULT:    apply_result(ev);
            OP_FG_REPORT: last_fg = ev.now_ms;
            OP_SUSPEND:   suspend_tiers(ev.now_ms, 64'(ev.suspend_seconds) * SEC_MS);
            OP_KICK:      kick_tiers(ev.now_ms);
            default: ;
        endcase
        st.health = hlth;
        st.slow   = speed;
        st.fg     = fg_flag;
        st.susp   = (ev.now_ms < susp_end);
        return st;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        status_t want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_status.size() == 0) begin
                $display("%0t: status transaction with no event outstanding", $time);
                errors++;
            end else begin
                want = pending_status.pop_front();
                check_field("fire_mask", 8'(want.fire), 8'(o_fire_mask));
                check_field("skip_mask", 8'(want.skip), 8'(o_skip_mask));
                check_field("health", 8'(want.health), 8'(o_health));
                check_field("slow_factor", 8'(want.slow), 8'(o_slow_factor));
                check_field("in_foreground", 8'(want.fg), 8'(o_in_foreground));
                check_field("is_suspended", 8'(want.susp), 8'(o_is_suspended));
            end
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    task automatic send_event(input poll_event_t ev);
        bit lowered;
        lowered = 1'b0;
        // insert sender gaps
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (!lowered) i_valid <= 1'b0;
            lowered = 1'b1;
            @(posedge i_clk);
        end
        i_op              <= ev.op;
        i_now_ms          <= ev.now_ms;
        i_result_ok       <= ev.result_ok;
        i_result_timeout  <= ev.result_timeout;
        i_queue_depth     <= ev.queue_depth;
        i_suspend_seconds <= ev.suspend_seconds;
        i_jitter_zero     <= ev.jitter[0];
        i_jitter_one      <= ev.jitter[1];
        i_jitter_two      <= ev.jitter[2];
        i_link_found      <= ev.link_found;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        n_events++;
        pending_status.push_back(advance_scheduler(ev));
    endtask

    // Drop valid and wait until every status has come back
    task automatic drain_results(input bit settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_IDLE_IV:   cfg_idle_iv   = val;
            CFG_ACTIVE_IV: cfg_active_iv = val;
            CFG_SIGNAL_IV: cfg_signal_iv = val;
            CFG_CELL_IV:   cfg_cell_iv   = val;
            CFG_SCALE:     cfg_scale     = val[4:0];
            CFG_ENABLE:    cfg_poll_en   = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] idle_v, input logic [15:0] active_v,
                                input logic [15:0] signal_v, input logic [15:0] cell_v,
                                input logic [4:0] scale_v, input logic enable_v);
        drain_results(1'b1);
        write_reg(CFG_IDLE_IV, idle_v);
        write_reg(CFG_ACTIVE_IV, active_v);
        write_reg(CFG_SIGNAL_IV, signal_v);
        write_reg(CFG_CELL_IV, cell_v);
        write_reg(CFG_SCALE, 16'(scale_v));
        write_reg(CFG_ENABLE, 16'(enable_v));
        i_cfg_we <= 1'b0;
    endtask

    function automatic poll_event_t quiet_event(input logic [2:0] op, input logic [47:0] now);
        poll_event_t ev;
        ev.op              = op;
        ev.now_ms          = now;
        ev.result_ok       = 1'b0;
        ev.result_timeout  = 1'b0;
        ev.queue_depth     = '0;
        ev.suspend_seconds = '0;
        for (int t = 0; t < 3; t++) ev.jitter[t] = '0;
        ev.link_found      = 1'b1;
        return ev;
    endfunction

    // Random fields, biased towards the interesting ranges
    function automatic poll_event_t rand_fields(input logic [2:0] op, input logic [47:0] now);
        poll_event_t ev;
        int unsigned r;
        r = $urandom_range(0, 99);
        ev.op              = op;
        ev.now_ms          = now;
        ev.result_ok       = (r < 25);
        ev.result_timeout  = (r < 25) ? 1'($urandom) : (r >= 40);
        ev.queue_depth     = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 4));
        ev.suspend_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20));
        for (int t = 0; t < 3; t++)
            ev.jitter[t] = ($urandom_range(0, 7) == 0) ? 14'($urandom)
                                                       : 14'($urandom_range(0, 9999));
        ev.link_found      = ($urandom_range(0, 15) != 0);
        return ev;
    endfunction

    // Mostly small forward steps, now and then a long leap or a jump anywhere
    function automatic logic [47:0] next_time(input logic [47:0] cur);
        int unsigned pick;
        pick = $urandom_range(0, 49);
        if (pick == 0) return {16'($urandom), $urandom};
        if (pick == 1) return {32'hFFFF_FFFF, 16'($urandom)};
        if (pick < 6)  return cur + $urandom_range(0, 4194304);
        if (pick < 16) return cur + $urandom_range(0, 40000);
        return cur + $urandom_range(0, 4000);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_tick_tiers();
        poll_event_t ev;
        logic [2:0] op;
        // tier 0 is due at once; a report at time zero still means never
        send_event(quiet_event(OP_TICK, 48'd0));
        send_event(quiet_event(OP_FG_REPORT, 48'd0));
        send_event(quiet_event(OP_TICK, 48'd500));
        send_event(quiet_event(OP_FG_REPORT, 48'd1000));
        // foreground now: signal and cell tiers come in
        send_event(quiet_event(OP_TICK, 48'd2000));
        // busy queue skips every due tier
        ev = quiet_event(OP_TICK, 48'd20000);
        ev.queue_depth = '1;
        send_event(ev);
        send_event(quiet_event(OP_KICK, 48'd20001));
        // jitter beyond its range, depth just under busy
        ev = quiet_event(OP_TICK, 48'd20001);
        ev.queue_depth = 8'(BUSY_DEPTH - 1);
        for (int t = 0; t < 3; t++) ev.jitter[t] = '1;
        send_event(ev);
        ev = quiet_event(OP_TICK, 48'd60000);
        ev.link_found = 1'b0;
        send_event(ev);
        // unused op codes change nothing
        for (op = OP_SPARE_LO; op != OP_SPARE_HI; op++)
            send_event(quiet_event(op, 48'd60001));
        send_event(quiet_event(OP_SPARE_HI, 48'd60001));
        // top of the time range: re-arm wraps
        send_event(quiet_event(OP_TICK, '1));
        ev = quiet_event(OP_RESULT, 48'd70000);
        send_event(ev);
    endtask

    task automatic test_suspend_wrap();
        poll_event_t ev;
        ev = quiet_event(OP_SUSPEND, 48'd500000);
        ev.suspend_seconds = '1;
        send_event(ev);
        send_event(quiet_event(OP_TICK, 48'd501000));
        send_event(quiet_event(OP_SUSPEND, 48'd502000));
        // suspend end wraps past zero, so it is already over
        ev = quiet_event(OP_SUSPEND, 48'hFFFF_FFFF_FC18);
        ev.suspend_seconds = 16'd5;
        send_event(ev);
        send_event(quiet_event(OP_TICK, 48'hFFFF_FFFF_FC18));
        send_event(quiet_event(OP_TICK, 48'd3000));
        clock_ms = 48'd10000;
    endtask

    task automatic test_poll_disable();
        program_regs(RST_IDLE_IV, RST_ACTIVE_IV, RST_SIGNAL_IV, RST_CELL_IV, RST_SCALE, 1'b0);
        send_event(quiet_event(OP_TICK, clock_ms));
        program_regs(RST_IDLE_IV, RST_ACTIVE_IV, RST_SIGNAL_IV, RST_CELL_IV, RST_SCALE, 1'b1);
    endtask

    // Run the timeout count past saturation while the receiver holds off
    task automatic test_breaker_under_backpressure();
        poll_event_t ev;
        int unsigned i;
        drain_results(1'b0);
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_cycles <= LONG_HOLD;
        clock_ms = clock_ms + 100000;
        for (i = 0; i < RUN_SWEEP; i++) begin
            clock_ms = clock_ms + 1;
            ev = quiet_event(OP_RESULT, clock_ms);
            ev.result_timeout = 1'b1;
            send_event(ev);
        end
        clock_ms = clock_ms + 200000;
        send_event(quiet_event(OP_TICK, clock_ms));
        ev = quiet_event(OP_RESULT, clock_ms + 1);
        ev.result_ok = 1'b1;
        send_event(ev);
        send_event(quiet_event(OP_TICK, clock_ms + 2));
        // sender pauses until everything is back
        drain_results(1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_v,
                                       input int unsigned count);
        poll_event_t ev;
        logic [2:0] op;
        int unsigned i, pick, burst;
        send_idle_pct = idle_pct;
        stall_pct <= stall_v;
        burst = 0;
        for (i = 0; i < count; i++) begin
            clock_ms = next_time(clock_ms);
            if (burst != 0) begin
                // run of timeouts to walk the breaker
                ev = rand_fields(OP_RESULT, clock_ms);
                ev.result_ok = 1'b0;
                ev.result_timeout = 1'b1;
                burst--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55)      op = OP_TICK;
                else if (pick < 67) op = OP_FG_REPORT;
                else if (pick < 85) op = OP_RESULT;
                else if (pick < 90) op = OP_SUSPEND;
                else if (pick < 96) op = OP_KICK;
                else                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                ev = rand_fields(op, clock_ms);
                if (op == OP_RESULT && $urandom_range(0, 7) == 0)
                    burst = $urandom_range(2, 10);
            end
            send_event(ev);
            if ($urandom_range(0, 39) == 0) drain_results(1'b0);
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_valid           <= 1'b0;
        i_op              <= '0;
        i_now_ms          <= '0;
        i_result_ok       <= 1'b0;
        i_result_timeout  <= 1'b0;
        i_queue_depth     <= '0;
        i_suspend_seconds <= '0;
        i_jitter_zero     <= '0;
        i_jitter_one      <= '0;
        i_jitter_two      <= '0;
        i_link_found      <= 1'b0;
        restore_defaults();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tick_tiers();
        test_suspend_wrap();
        test_poll_disable();
        test_breaker_under_backpressure();

        program_regs(16'd3000, 16'd1000, 16'd2000, 16'd0, 5'd1, 1'b1);
        test_random_traffic(0, 0, 50);
        program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 5'd16, 1'b1);
        test_random_traffic(51, 0, 50);
        program_regs(16'd0, 16'd500, 16'd1, 16'd100, 5'd0, 1'b1);
        test_random_traffic(0, 51, 50);
        program_regs(16'd1, 16'hFFFF, 16'd0, 16'd20000, 5'd31, 1'b1);
        test_random_traffic(29, 29, 50);

        drain_results(1'b1);
        $display("Covered %0d events, %0d of them ticks: %0d tier polls fired, %0d skipped busy",
                 n_events, n_ticks, n_fired, n_skipped);
        $display("Breaker went degraded %0d and dead %0d times, over five interval settings",
                 n_degraded, n_dead);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tpsb_pkg.sv
hw/rtl/tiered_poll_scheduler_breaker.sv
tb/sv/tb.sv
